[rtl/hungarian_track_association_assert.svh]
// Assertion macros used by the checker file.
`ifndef HUNGARIAN_TRACK_ASSOCIATION_ASSERT_SVH
`define HUNGARIAN_TRACK_ASSOCIATION_ASSERT_SVH

// Next-cycle implication, quiet while reset is held.
`define HTA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hta: next-cycle check failed");

// Same-cycle implication, checked during reset as well.
`define HTA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("hta: same-cycle check failed");

`endif

[rtl/hta_pkg.sv]
`default_nettype none

package hta_pkg;

    // Store sizes
    localparam int MAX_TRACKS     = 8;
    localparam int MAX_DETECTIONS = 8;
    localparam int MAX_COLS       = (MAX_TRACKS > MAX_DETECTIONS) ? MAX_TRACKS : MAX_DETECTIONS;

    localparam int TRK_IW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int DET_IW  = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
    localparam int COLI_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NUM_W   = $clog2(MAX_COLS + 1);
    localparam int ROW_W   = $clog2(MAX_TRACKS + 1);
    localparam int COST_AW = TRK_IW + COLI_W;
    localparam int COST_DEPTH = 1 << COST_AW;

    // Field widths
    localparam int POS_W  = 32;
    localparam int YAW_W  = 16;
    localparam int ID_W   = 16;
    localparam int WGT_W  = 16;
    localparam int INIT_W = 4;
    localparam int COST_W = 33;
    localparam int POT_W  = 42;

    // Configuration port
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 16;
    localparam logic [CFG_AW-1:0] REG_YAW_WEIGHT = 1'b0;
    localparam logic [CFG_AW-1:0] REG_INIT_COUNT = 1'b1;
    localparam logic [WGT_W-1:0]  WEIGHT_RESET   = 16'd128;
    localparam logic [INIT_W-1:0] INIT_RESET     = 4'd3;

    // Cost arithmetic
    localparam logic [16:0] PI_Q13     = 17'd25736;
    localparam logic [16:0] TWO_PI_Q13 = 17'd51472;
    localparam logic [30:0] POS_SAT    = 31'h7fff_ffff;
    localparam int          YAW_SHIFT  = 5;

    // Input queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [YAW_W-1:0] yaw;
        logic [ID_W-1:0]         id;
        logic                    last;
    } det_beat_t;

    typedef struct packed {
        logic signed [POS_W-1:0] trk_x;
        logic signed [POS_W-1:0] trk_y;
        logic signed [YAW_W-1:0] trk_yaw;
        logic signed [POS_W-1:0] det_x;
        logic signed [POS_W-1:0] det_y;
        logic signed [YAW_W-1:0] det_yaw;
    } cost_req_t;

endpackage

`default_nettype wire

[rtl/hta_queue.sv]
`default_nettype none

module hta_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire hta_pkg::det_beat_t push_beat,
    output logic                   pop_valid,
    input  wire logic              pop,
    output hta_pkg::det_beat_t     pop_beat
);

    hta_pkg::det_beat_t          slot_reg [hta_pkg::Q_DEPTH];
    logic [hta_pkg::Q_AW-1:0]    wr_ptr_reg;
    logic [hta_pkg::Q_AW-1:0]    rd_ptr_reg;
    logic [hta_pkg::Q_AW:0]      count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != (hta_pkg::Q_AW+1)'(hta_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_beat   = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Hold the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

`default_nettype wire

[rtl/hta_cost.sv]
`default_nettype none

module hta_cost
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire hta_pkg::cost_req_t         req,
    input  wire logic [hta_pkg::WGT_W-1:0]  weight,
    output logic                            done,
    output logic [hta_pkg::COST_W-1:0]      cost
);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_SQX  = 3'd1;
    localparam logic [2:0] C_SQY  = 3'd2;
    localparam logic [2:0] C_SUM  = 3'd3;
    localparam logic [2:0] C_TERM = 3'd4;
    localparam logic [2:0] C_ROOT = 3'd5;
    localparam logic [2:0] C_DONE = 3'd6;

    logic [2:0]   state_reg;
    logic [2:0]   state_next;
    logic [4:0]   step_reg;
    logic         done_reg;
    logic [30:0]  adx_reg;
    logic [30:0]  ady_reg;
    logic [16:0]  dyaw_reg;
    logic [63:0]  sq_reg;
    logic [61:0]  prod_reg;
    logic [32:0]  term_reg;
    logic [33:0]  rem_reg;
    logic [31:0]  root_reg;
    logic [hta_pkg::COST_W-1:0] cost_reg;

    logic signed [32:0] dxw;
    logic signed [32:0] dyw;
    logic [32:0]        dxm;
    logic [32:0]        dym;
    logic [30:0]        dxs;
    logic [30:0]        dys;
    logic signed [16:0] dhw;
    logic [16:0]        dhm;
    logic [16:0]        dhwrap;
    logic [35:0]        rem_sh;
    logic [35:0]        trial;
    logic               ge;

    // Saturated absolute position differences
    assign dxw = $signed({req.trk_x[31], req.trk_x}) - $signed({req.det_x[31], req.det_x});
    assign dyw = $signed({req.trk_y[31], req.trk_y}) - $signed({req.det_y[31], req.det_y});
    assign dxm = dxw[32] ? 33'(-dxw) : 33'(dxw);
    assign dym = dyw[32] ? 33'(-dyw) : 33'(dyw);
    assign dxs = (dxm > {2'b00, hta_pkg::POS_SAT}) ? hta_pkg::POS_SAT : dxm[30:0];
    assign dys = (dym > {2'b00, hta_pkg::POS_SAT}) ? hta_pkg::POS_SAT : dym[30:0];

    // Wrapped heading difference
    assign dhw = $signed({req.trk_yaw[15], req.trk_yaw})
               - $signed({req.det_yaw[15], req.det_yaw});
    assign dhm = dhw[16] ? 17'(-dhw) : 17'(dhw);
    always_comb
    begin
        if (dhm > hta_pkg::PI_Q13)
        begin
            dhwrap = (dhm >= hta_pkg::TWO_PI_Q13) ? 17'd0 : (hta_pkg::TWO_PI_Q13 - dhm);
        end
        else
        begin
            dhwrap = dhm;
        end
    end

    // One root bit per cycle
    assign rem_sh = {rem_reg, sq_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: if (start) state_next = C_SQX;
            C_SQX:  state_next = C_SQY;
            C_SQY:  state_next = C_SUM;
            C_SUM:  state_next = C_TERM;
            C_TERM: state_next = C_ROOT;
            C_ROOT: if (step_reg == 5'd31) state_next = C_DONE;
            C_DONE: state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == C_DONE);
            if (state_reg == C_ROOT)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    // Squares, weighted heading term and root
    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                adx_reg  <= dxs;
                ady_reg  <= dys;
                dyaw_reg <= dhwrap;
            end
            C_SQX:  prod_reg <= adx_reg * adx_reg;
            C_SQY:
            begin
                sq_reg   <= {2'b00, prod_reg};
                prod_reg <= ady_reg * ady_reg;
            end
            C_SUM:  sq_reg   <= sq_reg + {2'b00, prod_reg};
            C_TERM:
            begin
                term_reg <= weight * dyaw_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            C_ROOT:
            begin
                sq_reg   <= {sq_reg[61:0], 2'b00};
                rem_reg  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
                root_reg <= {root_reg[30:0], ge};
            end
            C_DONE:
            begin
                cost_reg <= hta_pkg::COST_W'(root_reg)
                          + hta_pkg::COST_W'(term_reg >> hta_pkg::YAW_SHIFT);
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign cost = cost_reg;

endmodule

`default_nettype wire

[rtl/hta_engine.sv]
`default_nettype none

module hta_engine
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [hta_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [hta_pkg::CFG_DW-1:0]  cfg_wdata,
    input  wire logic                        q_valid,
    input  wire hta_pkg::det_beat_t          q_beat,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [hta_pkg::ID_W-1:0]         trk_id,
    output logic signed [hta_pkg::POS_W-1:0] trk_x,
    output logic signed [hta_pkg::POS_W-1:0] trk_y,
    output logic signed [hta_pkg::YAW_W-1:0] trk_yaw,
    output logic                             seen,
    output logic                             last_track
);

    localparam int NW = hta_pkg::NUM_W;
    localparam int RW = hta_pkg::ROW_W;
    localparam int PW = hta_pkg::POT_W;
    localparam int NT = hta_pkg::MAX_TRACKS;
    localparam int ND = hta_pkg::MAX_DETECTIONS;
    localparam int NC = hta_pkg::MAX_COLS;
    localparam logic signed [PW-1:0] INF = {1'b0, {(PW-1){1'b1}}};

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_INIT      = 4'd1;
    localparam logic [3:0] ST_COST_SET  = 4'd2;
    localparam logic [3:0] ST_COST_WAIT = 4'd3;
    localparam logic [3:0] ST_SINIT     = 4'd4;
    localparam logic [3:0] ST_ROW       = 4'd5;
    localparam logic [3:0] ST_MARK      = 4'd6;
    localparam logic [3:0] ST_RD        = 4'd7;
    localparam logic [3:0] ST_EV        = 4'd8;
    localparam logic [3:0] ST_UPD       = 4'd9;
    localparam logic [3:0] ST_PATH      = 4'd10;
    localparam logic [3:0] ST_ASSIGN    = 4'd11;
    localparam logic [3:0] ST_EMIT_LD   = 4'd12;
    localparam logic [3:0] ST_EMIT_WT   = 4'd13;

    // Control state
    logic [3:0]                  state_reg;
    logic [3:0]                  state_next;
    logic [hta_pkg::WGT_W-1:0]   weight_reg;
    logic [hta_pkg::INIT_W-1:0]  init_reg;
    logic                        ready_reg;
    logic [NW-1:0]               tcount_reg;
    logic [NW-1:0]               dcount_reg;
    logic [NW-1:0]               fcount_reg;
    logic [NW-1:0]               m_reg;
    logic [NW-1:0]               ci_reg;
    logic [NW-1:0]               cj_reg;
    logic [NW-1:0]               k_reg;
    logic                        out_valid_reg;

    // Track and detection stores
    logic signed [hta_pkg::POS_W-1:0] pos_x_reg  [NT];
    logic signed [hta_pkg::POS_W-1:0] pos_y_reg  [NT];
    logic signed [hta_pkg::YAW_W-1:0] head_reg   [NT];
    logic [hta_pkg::ID_W-1:0]         ident_reg  [NT];
    logic                             tseen_reg  [NT];
    logic signed [hta_pkg::POS_W-1:0] dx_reg     [ND];
    logic signed [hta_pkg::POS_W-1:0] dy_reg     [ND];
    logic signed [hta_pkg::YAW_W-1:0] dyaw_reg   [ND];
    logic [hta_pkg::ID_W-1:0]         did_reg    [ND];

    // Cost memory
    logic [hta_pkg::COST_W-1:0] cost_mem [hta_pkg::COST_DEPTH];
    logic [hta_pkg::COST_W-1:0] cost_rd_reg;
    logic                       cost_we;
    logic [hta_pkg::COST_AW-1:0] cost_waddr;
    logic [hta_pkg::COST_W-1:0] cost_wdata;
    logic [hta_pkg::COST_AW-1:0] cost_raddr;

    // Solver state
    logic signed [PW-1:0] u_reg     [NT+1];
    logic signed [PW-1:0] v_reg     [NC+1];
    logic signed [PW-1:0] min_reg   [NC+1];
    logic [RW-1:0]        owner_reg [NC+1];
    logic [NW-1:0]        path_reg  [NC+1];
    logic                 used_reg  [NC+1];
    logic [RW-1:0]        row_reg;
    logic [RW-1:0]        r_reg;
    logic [NW-1:0]        col_reg;
    logic [NW-1:0]        j0_reg;
    logic [NW-1:0]        j1_reg;
    logic [NW:0]          guard_reg;
    logic signed [PW-1:0] ur_reg;
    logic signed [PW-1:0] s_reg;
    logic signed [PW-1:0] delta_reg;

    // Output payload
    logic [hta_pkg::ID_W-1:0]         oid_reg;
    logic signed [hta_pkg::POS_W-1:0] ox_reg;
    logic signed [hta_pkg::POS_W-1:0] oy_reg;
    logic signed [hta_pkg::YAW_W-1:0] oyaw_reg;
    logic                             oseen_reg;
    logic                             olast_reg;

    // Cost unit link
    hta_pkg::cost_req_t         creq;
    logic                       cstart;
    logic                       cdone;
    logic [hta_pkg::COST_W-1:0] cval;

    // Decodes
    logic                 pop_now;
    logic                 store_ok;
    logic [NW-1:0]        cnt_now;
    logic                 init_hit;
    logic                 pair_real;
    logic                 pair_last_col;
    logic                 pair_last;
    logic                 pair_adv;
    logic                 col_last;
    logic                 guard_ok;
    logic                 search_go;
    logic [NW-1:0]        path_j;
    logic                 path_go;
    logic                 row_last;
    logic                 emit_last;
    logic signed [PW-1:0] cur;
    logic                 cur_lt;
    logic signed [PW-1:0] mn;
    logic [RW-1:0]        asg_row;
    logic [NW-1:0]        col_m1;
    logic [RW-1:0]        r_m1;
    logic                 asg_hit;

    assign pop_now  = (state_reg == ST_IDLE) && q_valid;
    assign q_pop    = pop_now;
    assign store_ok = (dcount_reg < NW'(ND));
    assign cnt_now  = store_ok ? (dcount_reg + 1'b1) : dcount_reg;
    assign init_hit = ({{hta_pkg::INIT_W{1'b0}}, cnt_now} == {{NW{1'b0}}, init_reg});

    assign pair_real     = (cj_reg < fcount_reg);
    assign pair_last_col = ((cj_reg + 1'b1) == m_reg);
    assign pair_last     = pair_last_col && ((ci_reg + 1'b1) == tcount_reg);
    assign pair_adv      = ((state_reg == ST_COST_SET) && !pair_real)
                        || ((state_reg == ST_COST_WAIT) && cdone);

    assign col_last  = (col_reg == m_reg);
    assign guard_ok  = ((guard_reg + 1'b1) <= {1'b0, m_reg});
    assign search_go = (owner_reg[j1_reg] != '0) && guard_ok;
    assign path_j    = path_reg[j0_reg];
    assign path_go   = (path_j != '0) && guard_ok;
    assign row_last  = ({{(NW){1'b0}}, row_reg} == {{(RW){1'b0}}, tcount_reg});
    assign emit_last = ((k_reg + 1'b1) == tcount_reg);

    assign cur    = $signed({{(PW-hta_pkg::COST_W){1'b0}}, cost_rd_reg}) - s_reg;
    assign cur_lt = (cur < min_reg[col_reg]);
    assign mn     = cur_lt ? cur : min_reg[col_reg];

    assign asg_row = owner_reg[col_reg] - 1'b1;
    assign col_m1  = col_reg - 1'b1;
    assign r_m1    = r_reg - 1'b1;
    assign asg_hit = (owner_reg[col_reg] != '0) && (col_m1 < fcount_reg);

    // Cost unit operands and memory write
    assign creq.trk_x   = pos_x_reg[ci_reg[hta_pkg::TRK_IW-1:0]];
    assign creq.trk_y   = pos_y_reg[ci_reg[hta_pkg::TRK_IW-1:0]];
    assign creq.trk_yaw = head_reg[ci_reg[hta_pkg::TRK_IW-1:0]];
    assign creq.det_x   = dx_reg[cj_reg[hta_pkg::DET_IW-1:0]];
    assign creq.det_y   = dy_reg[cj_reg[hta_pkg::DET_IW-1:0]];
    assign creq.det_yaw = dyaw_reg[cj_reg[hta_pkg::DET_IW-1:0]];
    assign cstart       = (state_reg == ST_COST_SET) && pair_real;

    assign cost_we    = pair_adv;
    assign cost_waddr = {ci_reg[hta_pkg::TRK_IW-1:0], cj_reg[hta_pkg::COLI_W-1:0]};
    assign cost_wdata = (state_reg == ST_COST_WAIT) ? cval : '0;
    assign cost_raddr = {r_m1[hta_pkg::TRK_IW-1:0], col_m1[hta_pkg::COLI_W-1:0]};

    hta_cost u_cost
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cstart),
        .req    (creq),
        .weight (weight_reg),
        .done   (cdone),
        .cost   (cval)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_now && q_beat.last)
                begin
                    if (ready_reg)
                    begin
                        state_next = ST_COST_SET;
                    end
                    else if (init_hit)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:      state_next = ST_EMIT_LD;
            ST_COST_SET:
            begin
                if (pair_real)
                begin
                    state_next = ST_COST_WAIT;
                end
                else if (pair_last)
                begin
                    state_next = ST_SINIT;
                end
            end
            ST_COST_WAIT:
            begin
                if (cdone)
                begin
                    state_next = pair_last ? ST_SINIT : ST_COST_SET;
                end
            end
            ST_SINIT:     state_next = ST_ROW;
            ST_ROW:       state_next = ST_MARK;
            ST_MARK:      state_next = ST_RD;
            ST_RD:        state_next = ST_EV;
            ST_EV:        state_next = col_last ? ST_UPD : ST_RD;
            ST_UPD:
            begin
                if (col_last)
                begin
                    state_next = search_go ? ST_MARK : ST_PATH;
                end
            end
            ST_PATH:
            begin
                if (!path_go)
                begin
                    state_next = row_last ? ST_ASSIGN : ST_ROW;
                end
            end
            ST_ASSIGN:    state_next = col_last ? ST_EMIT_LD : ST_ASSIGN;
            ST_EMIT_LD:   state_next = ST_EMIT_WT;
            ST_EMIT_WT:
            begin
                if (out_ready)
                begin
                    state_next = emit_last ? ST_IDLE : ST_EMIT_LD;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            weight_reg    <= hta_pkg::WEIGHT_RESET;
            init_reg      <= hta_pkg::INIT_RESET;
            ready_reg     <= 1'b0;
            tcount_reg    <= '0;
            dcount_reg    <= '0;
            fcount_reg    <= '0;
            m_reg         <= '0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    hta_pkg::REG_YAW_WEIGHT: weight_reg <= cfg_wdata[hta_pkg::WGT_W-1:0];
                    hta_pkg::REG_INIT_COUNT: init_reg   <= cfg_wdata[hta_pkg::INIT_W-1:0];
                    default: ;
                endcase
            end

            // Count the beat and close the frame
            if (pop_now)
            begin
                dcount_reg <= cnt_now;
                if (q_beat.last)
                begin
                    dcount_reg <= '0;
                    fcount_reg <= cnt_now;
                    m_reg      <= (cnt_now > tcount_reg) ? cnt_now : tcount_reg;
                    ci_reg     <= '0;
                    cj_reg     <= '0;
                    k_reg      <= '0;
                    if (!ready_reg && init_hit)
                    begin
                        ready_reg  <= 1'b1;
                        tcount_reg <= cnt_now;
                        m_reg      <= cnt_now;
                    end
                end
            end

            // Walk the cost matrix
            if (pair_adv)
            begin
                if (pair_last_col)
                begin
                    cj_reg <= '0;
                    ci_reg <= ci_reg + 1'b1;
                end
                else
                begin
                    cj_reg <= cj_reg + 1'b1;
                end
            end

            // Result handshake
            if (state_reg == ST_EMIT_LD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if ((state_reg == ST_EMIT_WT) && out_ready)
            begin
                out_valid_reg <= 1'b0;
                k_reg         <= k_reg + 1'b1;
            end
        end
    end

    // Cost memory
    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[cost_waddr] <= cost_wdata;
        end
        if (state_reg == ST_RD)
        begin
            cost_rd_reg <= cost_mem[cost_raddr];
        end
    end

    // Stores, solver datapath and result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_now)
                begin
                    if (store_ok)
                    begin
                        dx_reg[dcount_reg[hta_pkg::DET_IW-1:0]]   <= q_beat.x;
                        dy_reg[dcount_reg[hta_pkg::DET_IW-1:0]]   <= q_beat.y;
                        dyaw_reg[dcount_reg[hta_pkg::DET_IW-1:0]] <= q_beat.yaw;
                        did_reg[dcount_reg[hta_pkg::DET_IW-1:0]]  <= q_beat.id;
                    end
                    if (q_beat.last && ready_reg)
                    begin
                        for (int i = 0; i < NT; i++)
                        begin
                            tseen_reg[i] <= 1'b0;
                        end
                    end
                end
            end
            ST_INIT:
            begin
                for (int i = 0; i < NT; i++)
                begin
                    if (i < ND)
                    begin
                        pos_x_reg[i] <= dx_reg[i];
                        pos_y_reg[i] <= dy_reg[i];
                        head_reg[i]  <= dyaw_reg[i];
                        ident_reg[i] <= did_reg[i];
                    end
                    tseen_reg[i] <= 1'b1;
                end
            end
            ST_SINIT:
            begin
                for (int i = 0; i <= NT; i++)
                begin
                    u_reg[i] <= '0;
                end
                for (int j = 0; j <= NC; j++)
                begin
                    v_reg[j]     <= '0;
                    owner_reg[j] <= '0;
                    path_reg[j]  <= '0;
                end
                row_reg <= RW'(1);
            end
            ST_ROW:
            begin
                owner_reg[0] <= row_reg;
                for (int j = 0; j <= NC; j++)
                begin
                    min_reg[j]  <= INF;
                    used_reg[j] <= 1'b0;
                end
                j0_reg    <= '0;
                guard_reg <= '0;
            end
            ST_MARK:
            begin
                used_reg[j0_reg] <= 1'b1;
                r_reg            <= owner_reg[j0_reg];
                ur_reg           <= u_reg[owner_reg[j0_reg]];
                delta_reg        <= INF;
                j1_reg           <= '0;
                col_reg          <= NW'(1);
            end
            ST_RD:
            begin
                s_reg <= ur_reg + v_reg[col_reg];
            end
            ST_EV:
            begin
                if (!used_reg[col_reg])
                begin
                    if (cur_lt)
                    begin
                        min_reg[col_reg]  <= cur;
                        path_reg[col_reg] <= j0_reg;
                    end
                    if (mn < delta_reg)
                    begin
                        delta_reg <= mn;
                        j1_reg    <= col_reg;
                    end
                end
                col_reg <= col_last ? '0 : (col_reg + 1'b1);
            end
            ST_UPD:
            begin
                if (used_reg[col_reg])
                begin
                    u_reg[owner_reg[col_reg]] <= u_reg[owner_reg[col_reg]] + delta_reg;
                    v_reg[col_reg]            <= v_reg[col_reg] - delta_reg;
                end
                else
                begin
                    min_reg[col_reg] <= min_reg[col_reg] - delta_reg;
                end
                if (col_last)
                begin
                    j0_reg    <= j1_reg;
                    guard_reg <= search_go ? (guard_reg + 1'b1) : '0;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            ST_PATH:
            begin
                owner_reg[j0_reg] <= owner_reg[path_j];
                j0_reg            <= path_j;
                if (path_go)
                begin
                    guard_reg <= guard_reg + 1'b1;
                end
                else if (!row_last)
                begin
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= NW'(1);
                end
            end
            ST_ASSIGN:
            begin
                if (asg_hit)
                begin
                    pos_x_reg[asg_row[hta_pkg::TRK_IW-1:0]] <= dx_reg[col_m1[hta_pkg::DET_IW-1:0]];
                    pos_y_reg[asg_row[hta_pkg::TRK_IW-1:0]] <= dy_reg[col_m1[hta_pkg::DET_IW-1:0]];
                    head_reg[asg_row[hta_pkg::TRK_IW-1:0]]  <= dyaw_reg[col_m1[hta_pkg::DET_IW-1:0]];
                    tseen_reg[asg_row[hta_pkg::TRK_IW-1:0]] <= 1'b1;
                end
                col_reg <= col_reg + 1'b1;
            end
            ST_EMIT_LD:
            begin
                oid_reg   <= ident_reg[k_reg[hta_pkg::TRK_IW-1:0]];
                ox_reg    <= pos_x_reg[k_reg[hta_pkg::TRK_IW-1:0]];
                oy_reg    <= pos_y_reg[k_reg[hta_pkg::TRK_IW-1:0]];
                oyaw_reg  <= head_reg[k_reg[hta_pkg::TRK_IW-1:0]];
                oseen_reg <= tseen_reg[k_reg[hta_pkg::TRK_IW-1:0]];
                olast_reg <= emit_last;
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign trk_id     = oid_reg;
    assign trk_x      = ox_reg;
    assign trk_y      = oy_reg;
    assign trk_yaw    = oyaw_reg;
    assign seen       = oseen_reg;
    assign last_track = olast_reg;

endmodule

`default_nettype wire

[rtl/hungarian_track_association.sv]
// Track association by minimum-cost assignment.
// Input channel (in_valid/in_ready): one detection beat per cycle while the
// queue has room (det_x, det_y, det_yaw, det_id, frame_end). Beats go into a
// four-deep queue, so the input keeps taking beats while the engine works or
// the output is stalled, until the queue is full. A beat without frame_end is
// buffered and then stored by the idle engine. A frame-end beat starts the
// frame work: before initialisation a frame of exactly init_count detections
// becomes the track set; afterwards every track/detection cost is computed in
// the serial cost unit, with its one-bit-per-cycle square root, then the
// assignment is solved (up to m+1 search steps per row).
// Output channel (out_valid/out_ready): one beat per track, with a reload gap
// between beats, last_track on the final beat. A stalled receiver holds the
// engine; the queue still fills.
// Configuration: cfg_wr_en with cfg_addr 0 (yaw_weight) or 1 (init_count),
// write only while idle.
// Reset (rst_n low, asynchronous): uninitialised, no tracks, queue empty,
// yaw_weight 128, init_count 3.
`default_nettype none

module hungarian_track_association
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [hta_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [hta_pkg::CFG_DW-1:0]  cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [31:0]          det_x,
    input  wire logic signed [31:0]          det_y,
    input  wire logic signed [15:0]          det_yaw,
    input  wire logic [15:0]                 det_id,
    input  wire logic                        frame_end,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [15:0]                      trk_id,
    output logic signed [31:0]               trk_x,
    output logic signed [31:0]               trk_y,
    output logic signed [15:0]               trk_yaw,
    output logic                             seen,
    output logic                             last_track
);

    hta_pkg::det_beat_t in_beat;
    hta_pkg::det_beat_t q_beat;
    logic               q_valid;
    logic               q_pop;

    // Pack the input beat
    assign in_beat.x    = det_x;
    assign in_beat.y    = det_y;
    assign in_beat.yaw  = det_yaw;
    assign in_beat.id   = det_id;
    assign in_beat.last = frame_end;

    hta_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_beat  (in_beat),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_beat   (q_beat)
    );

    hta_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .q_valid    (q_valid),
        .q_beat     (q_beat),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .trk_id     (trk_id),
        .trk_x      (trk_x),
        .trk_y      (trk_y),
        .trk_yaw    (trk_yaw),
        .seen       (seen),
        .last_track (last_track)
    );

endmodule

`default_nettype wire

[rtl/hta_checker.sv]
`default_nettype none
`include "hungarian_track_association_assert.svh"

module hta_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] trk_id,
    input wire logic [31:0] trk_x,
    input wire logic [31:0] trk_y,
    input wire logic [15:0] trk_yaw,
    input wire logic        seen,
    input wire logic        last_track
);

    // No result beat while reset is held
    `HTA_ASSERT_NOW(a_reset_quiet, !rst_n, !out_valid)

    // Each taken result is followed by a reload gap
    `HTA_ASSERT_NEXT(a_gap_after_beat, out_valid && out_ready, !out_valid)

    // A stalled result stays offered
    `HTA_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid)

    // A stalled result keeps its payload
    `HTA_ASSERT_NEXT(a_hold_data, out_valid && !out_ready,
        $stable(trk_id) && $stable(trk_x) && $stable(trk_y) && $stable(trk_yaw) && $stable(seen) && $stable(last_track))

endmodule

bind hungarian_track_association hta_checker u_hta_checker (.*);

`default_nettype wire
